// File: hw/rtl/tcpq_pkg.sv
// Package for the two-class priority queue unit.
// Holds sizes, the entry type, status, command and register codes.
// No dependencies.
`timescale 1ns / 1ps

package tcpq_pkg;

  localparam int URGENT_DEPTH  = 64;
  localparam int REGULAR_DEPTH = 64;

  localparam int UIDX_W = $clog2(URGENT_DEPTH);
  localparam int UCNT_W = $clog2(URGENT_DEPTH + 1);
  localparam int RIDX_W = $clog2(REGULAR_DEPTH);
  localparam int RCNT_W = $clog2(REGULAR_DEPTH + 1);

  localparam int ID_W     = 16;
  localparam int SEV_W    = 4;
  localparam int RAW_W    = 8;
  localparam int STATUS_W = 3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STS_QUEUED_URGENT  = 3'd0;
  localparam status_t STS_QUEUED_REGULAR = 3'd1;
  localparam status_t STS_SERVED         = 3'd2;
  localparam status_t STS_NONE_WAITING   = 3'd3;
  localparam status_t STS_FULL           = 3'd4;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_SERVE   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ID  = 1'd1;

  localparam logic [SEV_W-1:0] THRESHOLD_RESET = 4'd6;
  localparam logic [ID_W-1:0]  FIRST_ID_RESET  = 16'd1001;
  localparam logic [SEV_W-1:0] SEV_MIN         = 4'd1;
  localparam logic [SEV_W-1:0] SEV_MAX         = 4'd10;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [SEV_W-1:0] sev;
  } slot_t;

  function automatic logic [SEV_W-1:0] clamp_severity(input logic signed [RAW_W-1:0] raw);
    logic [SEV_W-1:0] res;
    if (raw < 8'sd1) begin
      res = SEV_MIN;
    end else if (raw > 8'sd10) begin
      res = SEV_MAX;
    end else begin
      res = raw[SEV_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/tcpq_if.sv
// Valid/ready channel interfaces for the priority queue unit.
// Depends on tcpq_pkg.
`timescale 1ns / 1ps

interface tcpq_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   cmd;
  logic signed [tcpq_pkg::RAW_W-1:0]      raw_severity;

  modport source(output valid, cmd, raw_severity, input ready);
  modport sink(input valid, cmd, raw_severity, output ready);
endinterface

interface tcpq_out_if;
  logic                          valid;
  logic                          ready;
  logic [tcpq_pkg::STATUS_W-1:0] status;
  logic [tcpq_pkg::ID_W-1:0]     entry_id;
  logic [tcpq_pkg::SEV_W-1:0]    entry_severity;
  logic                          was_urgent;

  modport source(output valid, status, entry_id, entry_severity, was_urgent, input ready);
  modport sink(input valid, status, entry_id, entry_severity, was_urgent, output ready);
endinterface

// File: hw/rtl/two_class_priority_queue_unit.sv
// Two-class strict-priority scheduler: sorted urgent store plus regular FIFO.
// Depends on tcpq_pkg and the channel interfaces in tcpq_if.sv.
`timescale 1ns / 1ps

// One beat is taken at a time; in_chan.ready is low while it is worked on.
// A regular enqueue, a rejected enqueue or a serve with nothing waiting goes
// straight to the output state; a serve first does one registered memory read.
// An urgent enqueue walks the sorted store from its top through its single read
// port and one severity compare: each stored urgent entry of equal or higher
// severity is read, compared and moved up one slot, and the new entry is written
// into the slot left free, the lowest slot when every stored entry moves. The
// urgent store keeps the next entry to serve at its highest occupied slot.
// Results wait in an output register, so the next beat can be taken while the
// previous result is still pending.
module two_class_priority_queue_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  tcpq_in_if.sink                            in_chan,
  tcpq_out_if.source                         out_chan,
  input  logic                               cfg_we,
  input  logic [tcpq_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [tcpq_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_IRD  = 3'd1;
  localparam logic [2:0] S_ICMP = 3'd2;
  localparam logic [2:0] S_SRD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;

  logic [tcpq_pkg::SEV_W-1:0]  thr_r, thr_nxt;
  logic [tcpq_pkg::ID_W-1:0]   next_id_r, next_id_nxt;
  logic [tcpq_pkg::UCNT_W-1:0] ucount_r, ucount_nxt;
  logic [tcpq_pkg::RIDX_W-1:0] fhead_r, fhead_nxt;
  logic [tcpq_pkg::RIDX_W-1:0] ftail_r, ftail_nxt;
  logic [tcpq_pkg::RCNT_W-1:0] fcount_r, fcount_nxt;

  logic [tcpq_pkg::UCNT_W-1:0] pos_r, pos_nxt;
  tcpq_pkg::slot_t             new_r, new_nxt;
  tcpq_pkg::status_t           res_status_r, res_status_nxt;
  logic [tcpq_pkg::ID_W-1:0]   res_id_r, res_id_nxt;
  logic [tcpq_pkg::SEV_W-1:0]  res_sev_r, res_sev_nxt;
  logic                        res_urg_r, res_urg_nxt;

  logic                        out_valid_r, out_valid_nxt;
  tcpq_pkg::status_t           out_status_r;
  logic [tcpq_pkg::ID_W-1:0]   out_id_r;
  logic [tcpq_pkg::SEV_W-1:0]  out_sev_r;
  logic                        out_urg_r;
  logic                        out_load;

  tcpq_pkg::slot_t             umem [tcpq_pkg::URGENT_DEPTH];
  tcpq_pkg::slot_t             fmem [tcpq_pkg::REGULAR_DEPTH];
  tcpq_pkg::slot_t             u_rdata_r, f_rdata_r, u_wdata, f_wdata;
  logic                        u_re, u_we, f_re, f_we;
  logic [tcpq_pkg::UIDX_W-1:0] u_raddr, u_waddr;

  logic                        accept;
  logic [tcpq_pkg::SEV_W-1:0]  in_sev;
  logic                        in_urg;
  logic [tcpq_pkg::UCNT_W-1:0] pos_m1, ucount_m1;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign in_sev        = tcpq_pkg::clamp_severity(in_chan.raw_severity);
  assign in_urg        = (in_sev >= thr_r);
  assign pos_m1        = pos_r - 1'b1;
  assign ucount_m1     = ucount_r - 1'b1;
  assign out_load      = (state_r == S_OUT) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt      = state_r;
    thr_nxt        = thr_r;
    next_id_nxt    = next_id_r;
    ucount_nxt     = ucount_r;
    fhead_nxt      = fhead_r;
    ftail_nxt      = ftail_r;
    fcount_nxt     = fcount_r;
    pos_nxt        = pos_r;
    new_nxt        = new_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_sev_nxt    = res_sev_r;
    res_urg_nxt    = res_urg_r;
    u_re           = 1'b0;
    u_we           = 1'b0;
    u_raddr        = pos_m1[tcpq_pkg::UIDX_W-1:0];
    u_waddr        = pos_r[tcpq_pkg::UIDX_W-1:0];
    u_wdata        = new_r;
    f_re           = 1'b0;
    f_we           = 1'b0;
    f_wdata        = '{id: next_id_r, sev: in_sev};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_chan.cmd == tcpq_pkg::CMD_ENQUEUE) begin
            res_id_nxt  = next_id_r;
            res_sev_nxt = in_sev;
            res_urg_nxt = in_urg;
            if (in_urg) begin
              if (ucount_r == tcpq_pkg::UCNT_W'(tcpq_pkg::URGENT_DEPTH)) begin
                res_status_nxt = tcpq_pkg::STS_FULL;
                state_nxt      = S_OUT;
              end else begin
                res_status_nxt = tcpq_pkg::STS_QUEUED_URGENT;
                pos_nxt        = ucount_r;
                ucount_nxt     = ucount_r + 1'b1;
                new_nxt        = '{id: next_id_r, sev: in_sev};
                next_id_nxt    = next_id_r + 1'b1;
                state_nxt      = S_IRD;
              end
            end else begin
              if (fcount_r == tcpq_pkg::RCNT_W'(tcpq_pkg::REGULAR_DEPTH)) begin
                res_status_nxt = tcpq_pkg::STS_FULL;
              end else begin
                res_status_nxt = tcpq_pkg::STS_QUEUED_REGULAR;
                f_we           = 1'b1;
                if (ftail_r == tcpq_pkg::RIDX_W'(tcpq_pkg::REGULAR_DEPTH - 1)) begin
                  ftail_nxt = '0;
                end else begin
                  ftail_nxt = ftail_r + 1'b1;
                end
                fcount_nxt  = fcount_r + 1'b1;
                next_id_nxt = next_id_r + 1'b1;
              end
              state_nxt = S_OUT;
            end
          end else begin
            if (ucount_r != '0) begin
              res_status_nxt = tcpq_pkg::STS_SERVED;
              res_urg_nxt    = 1'b1;
              u_re           = 1'b1;
              u_raddr        = ucount_m1[tcpq_pkg::UIDX_W-1:0];
              ucount_nxt     = ucount_m1;
              state_nxt      = S_SRD;
            end else if (fcount_r != '0) begin
              res_status_nxt = tcpq_pkg::STS_SERVED;
              res_urg_nxt    = 1'b0;
              f_re           = 1'b1;
              if (fhead_r == tcpq_pkg::RIDX_W'(tcpq_pkg::REGULAR_DEPTH - 1)) begin
                fhead_nxt = '0;
              end else begin
                fhead_nxt = fhead_r + 1'b1;
              end
              fcount_nxt = fcount_r - 1'b1;
              state_nxt  = S_SRD;
            end else begin
              res_status_nxt = tcpq_pkg::STS_NONE_WAITING;
              res_id_nxt     = '0;
              res_sev_nxt    = '0;
              res_urg_nxt    = 1'b0;
              state_nxt      = S_OUT;
            end
          end
        end
      end
      S_IRD: begin
        if (pos_r == '0) begin
          u_we      = 1'b1;
          state_nxt = S_OUT;
        end else begin
          u_re      = 1'b1;
          state_nxt = S_ICMP;
        end
      end
      S_ICMP: begin
        u_we = 1'b1;
        if (u_rdata_r.sev >= new_r.sev) begin
          // equal or higher severity moves up and stays ahead of the new entry
          u_wdata   = u_rdata_r;
          pos_nxt   = pos_m1;
          state_nxt = S_IRD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_SRD: begin
        res_id_nxt  = res_urg_r ? u_rdata_r.id : f_rdata_r.id;
        res_sev_nxt = res_urg_r ? u_rdata_r.sev : f_rdata_r.sev;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_idx)
        tcpq_pkg::CFG_THRESHOLD: thr_nxt     = cfg_wdata[tcpq_pkg::SEV_W-1:0];
        tcpq_pkg::CFG_FIRST_ID:  next_id_nxt = cfg_wdata[tcpq_pkg::ID_W-1:0];
        default: begin
        end
      endcase
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= tcpq_pkg::THRESHOLD_RESET;
      next_id_r   <= tcpq_pkg::FIRST_ID_RESET;
      ucount_r    <= '0;
      fhead_r     <= '0;
      ftail_r     <= '0;
      fcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      thr_r       <= thr_nxt;
      next_id_r   <= next_id_nxt;
      ucount_r    <= ucount_nxt;
      fhead_r     <= fhead_nxt;
      ftail_r     <= ftail_nxt;
      fcount_r    <= fcount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    new_r        <= new_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_sev_r    <= res_sev_nxt;
    res_urg_r    <= res_urg_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_sev_r    <= res_sev_r;
      out_urg_r    <= res_urg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (u_we) begin
      umem[u_waddr] <= u_wdata;
    end
    if (u_re) begin
      u_rdata_r <= umem[u_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      fmem[ftail_r] <= f_wdata;
    end
    if (f_re) begin
      f_rdata_r <= fmem[fhead_r];
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.entry_id       = out_id_r;
  assign out_chan.entry_severity = out_sev_r;
  assign out_chan.was_urgent     = out_urg_r;

endmodule

// File: hw/rtl/tcpq_checker.sv
// Port-level assertions for the two-class priority queue unit, with its bind.
// Depends on tcpq_pkg and two_class_priority_queue_unit.
`timescale 1ns / 1ps

module tcpq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tcpq_pkg::STATUS_W-1:0] status,
  input logic [tcpq_pkg::ID_W-1:0]     entry_id,
  input logic [tcpq_pkg::SEV_W-1:0]    entry_severity,
  input logic                          was_urgent
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_id)
      && $stable(entry_severity) && $stable(was_urgent))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again in the cycle after a beat");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == tcpq_pkg::STS_NONE_WAITING |->
      entry_id == '0 && entry_severity == '0 && !was_urgent)
    else $error("empty serve carries a nonzero entry");

  a_sev_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != tcpq_pkg::STS_NONE_WAITING |->
      entry_severity >= tcpq_pkg::SEV_MIN && entry_severity <= tcpq_pkg::SEV_MAX)
    else $error("entry severity outside clamp range");

  a_class_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == tcpq_pkg::STS_QUEUED_URGENT
      || status == tcpq_pkg::STS_QUEUED_REGULAR) |->
      was_urgent == (status == tcpq_pkg::STS_QUEUED_URGENT))
    else $error("queued status disagrees with class flag");

endmodule

bind two_class_priority_queue_unit tcpq_checker u_tcpq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .status         (out_chan.status),
  .entry_id       (out_chan.entry_id),
  .entry_severity (out_chan.entry_severity),
  .was_urgent     (out_chan.was_urgent)
);

// File: tb/sv/testbench.sv
// Self-checking bench for two_class_priority_queue_unit: drives enqueue and serve
// beats, predicts every result with an internal scheduler model, checks in order.
// Depends on tcpq_pkg, tcpq_if.sv and the unit itself.
`timescale 1ns / 1ps

module testbench;

  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    tcpq_pkg::status_t          status;
    logic [tcpq_pkg::ID_W-1:0]  id;
    logic [tcpq_pkg::SEV_W-1:0] sev;
    logic                       urgent;
  } outcome_t;

  class sched_checker;
    logic [tcpq_pkg::SEV_W-1:0] threshold;
    logic [tcpq_pkg::ID_W-1:0]  next_id;
    tcpq_pkg::slot_t            urgent_q[$];
    tcpq_pkg::slot_t            regular_q[$];
    outcome_t                   due_results[$];
    int                         errors;

    function new();
      threshold = tcpq_pkg::THRESHOLD_RESET;
      next_id   = tcpq_pkg::FIRST_ID_RESET;
      errors    = 0;
    endfunction

    function void apply_reg(logic [tcpq_pkg::CFG_IDX_W-1:0] idx,
                            logic [tcpq_pkg::CFG_DATA_W-1:0] data);
      if (idx == tcpq_pkg::CFG_THRESHOLD) begin
        threshold = data[tcpq_pkg::SEV_W-1:0];
      end else if (idx == tcpq_pkg::CFG_FIRST_ID) begin
        next_id = data[tcpq_pkg::ID_W-1:0];
      end
    endfunction

    function void note_request(logic cmd, logic signed [tcpq_pkg::RAW_W-1:0] raw);
      outcome_t        res;
      tcpq_pkg::slot_t s;
      int              level;
      int              pos;
      if (cmd == tcpq_pkg::CMD_ENQUEUE) begin
        level = raw;
        if (level < 1) level = 1;
        if (level > 10) level = 10;
        s.id       = next_id;
        s.sev      = level[tcpq_pkg::SEV_W-1:0];
        res.id     = s.id;
        res.sev    = s.sev;
        res.urgent = (s.sev >= threshold);
        if ((res.urgent && urgent_q.size() >= tcpq_pkg::URGENT_DEPTH) ||
            (!res.urgent && regular_q.size() >= tcpq_pkg::REGULAR_DEPTH)) begin
          res.status = tcpq_pkg::STS_FULL;
        end else if (res.urgent) begin
          // equal severities keep arrival order
          pos = urgent_q.size();
          while (pos > 0 && urgent_q[pos-1].sev < s.sev) pos--;
          urgent_q.insert(pos, s);
          next_id++;
          res.status = tcpq_pkg::STS_QUEUED_URGENT;
        end else begin
          regular_q.insert(regular_q.size(), s);
          next_id++;
          res.status = tcpq_pkg::STS_QUEUED_REGULAR;
        end
      end else if (urgent_q.size() > 0) begin
        s   = urgent_q.pop_front();
        res = '{tcpq_pkg::STS_SERVED, s.id, s.sev, 1'b1};
      end else if (regular_q.size() > 0) begin
        s   = regular_q.pop_front();
        res = '{tcpq_pkg::STS_SERVED, s.id, s.sev, 1'b0};
      end else begin
        res = '{tcpq_pkg::STS_NONE_WAITING, 16'd0, 4'd0, 1'b0};
      end
      due_results.insert(due_results.size(), res);
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: unexpected result status=%0d id=%0d sev=%0d urgent=%0d",
                   $time, got.status, got.id, got.sev, got.urgent);
        end
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status || got.id !== want.id ||
          got.sev !== want.sev || got.urgent !== want.urgent) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: mismatch exp status=%0d id=%0d sev=%0d urgent=%0d", $time,
                   want.status, want.id, want.sev, want.urgent);
          $display("%0t:          got status=%0d id=%0d sev=%0d urgent=%0d", $time,
                   got.status, got.id, got.sev, got.urgent);
        end
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [tcpq_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [tcpq_pkg::CFG_DATA_W-1:0] cfg_wdata;
  bit                              no_idle;
  bit                              long_hold;
  sched_checker                    sb;

  tcpq_in_if  in_chan();
  tcpq_out_if out_chan();

  two_class_priority_queue_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  wire in_fire  = in_chan.valid && in_chan.ready;
  wire out_fire = out_chan.valid && out_chan.ready;

  always @(posedge clk) begin
    if (rst_n && in_fire) begin
      sb.note_request(in_chan.cmd, in_chan.raw_severity);
    end
    if (rst_n && out_fire) begin
      sb.check_result('{out_chan.status, out_chan.entry_id, out_chan.entry_severity,
                        out_chan.was_urgent});
    end
  end

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (in_fire || out_fire) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL two_class_priority_queue_unit");
    $finish;
  end

  function automatic logic [tcpq_pkg::RAW_W-1:0] pick_raw();
    int v;
    if ($urandom_range(0, 3) == 0) begin
      v = int'($urandom_range(0, 255));
    end else begin
      v = int'($urandom_range(0, 16)) - 3;
    end
    return v[tcpq_pkg::RAW_W-1:0];
  endfunction

  task automatic send_item(input logic cmd, input logic [tcpq_pkg::RAW_W-1:0] raw);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.cmd          <= cmd;
    in_chan.raw_severity <= raw;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    while (sb.due_results.size() != 0 || !in_chan.ready) @(negedge clk);
  endtask

  task automatic write_reg(input logic [tcpq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tcpq_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.apply_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [tcpq_pkg::SEV_W-1:0] thr,
                           input logic [tcpq_pkg::ID_W-1:0] first,
                           input int count, input int enq_pct, input bit hold);
    settle();
    write_reg(tcpq_pkg::CFG_THRESHOLD, {12'($urandom), thr});
    write_reg(tcpq_pkg::CFG_FIRST_ID, first);
    long_hold = hold;
    repeat (count) begin
      if ($urandom_range(1, 100) <= enq_pct) begin
        send_item(tcpq_pkg::CMD_ENQUEUE, pick_raw());
      end else begin
        send_item(tcpq_pkg::CMD_SERVE, pick_raw());
      end
    end
  endtask

  initial begin
    logic [tcpq_pkg::RAW_W-1:0] corner_sev[10];
    sb                   = new();
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.cmd          = tcpq_pkg::CMD_ENQUEUE;
    in_chan.raw_severity = '0;
    cfg_we               = 1'b0;
    cfg_idx              = tcpq_pkg::CFG_THRESHOLD;
    cfg_wdata            = '0;
    no_idle              = 1'b0;
    long_hold            = 1'b0;
    corner_sev = '{8'h80, 8'h7F, 8'h00, 8'h01, 8'h05, 8'h06, 8'h09, 8'h0A, 8'h0B, 8'hFF};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset config: empty serve, clamp corners, ties at the top severity, drain
    send_item(tcpq_pkg::CMD_SERVE, 8'h00);
    foreach (corner_sev[i]) send_item(tcpq_pkg::CMD_ENQUEUE, corner_sev[i]);
    repeat (11) send_item(tcpq_pkg::CMD_SERVE, pick_raw());

    run_phase(4'd0, 16'd65530, 80, 100, 1'b0);
    run_phase(4'd15, 16'd0, 80, 100, 1'b0);
    run_phase(4'd10, 16'hFFFF, 200, 30, 1'b0);
    run_phase(4'd1, 16'($urandom), 300, 55, 1'b0);
    run_phase(4'd11, 16'($urandom), 300, 60, 1'b1);
    repeat (4) begin
      no_idle = ($urandom_range(0, 2) == 0);
      run_phase(4'($urandom_range(0, 15)), 16'($urandom), 250,
                $urandom_range(45, 65), 1'b0);
    end
    no_idle = 1'b1;
    run_phase(4'd6, 16'($urandom), 200, 25, 1'b0);

    in_chan.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("PASS two_class_priority_queue_unit");
    end else begin
      $display("FAIL two_class_priority_queue_unit");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/tcpq_pkg.sv
hw/rtl/tcpq_if.sv
hw/rtl/two_class_priority_queue_unit.sv
hw/rtl/tcpq_checker.sv
tb/sv/testbench.sv
